>>> design/unix_time_calendar_converter_assert.svh
// ----------------------------------------------------------------------------
// Unix time calendar converter assertion macros
// Concurrent check macros used by the converter; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef UNIX_TIME_CALENDAR_CONVERTER_ASSERT_SVH
`define UNIX_TIME_CALENDAR_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
`define UTC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("converter check failed");
`define UTC_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("converter sequence check failed");
`else
`define UTC_ASSERT(lbl, prop)
`define UTC_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

>>> design/utcc_pkg.sv
// ----------------------------------------------------------------------------
// Unix time calendar converter package
// Constants, tables, request kinds, sequencer states and leap year helpers.
// ----------------------------------------------------------------------------
package utcc_pkg;

   localparam logic [31:0] EPOCH_2000 = 32'd946684800;

   localparam logic [5:0] DIVISOR [3] = '{6'd60, 6'd60, 6'd24};

   // reciprocals for exact 32-bit quotients: by 60 take bits 63:37, by 24 bits 63:36
   localparam logic [31:0] RECIP_60 = 32'h8888_8889;
   localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;

   localparam logic [5:0] MAC_MUL [4] = '{6'd24, 6'd60, 6'd60, 6'd1};

   localparam logic [4:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   localparam logic [8:0] DAYS_BEFORE [16] = '{
      9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365
   };

   typedef enum logic {
      REQ_TO_DATE    = 1'b0,
      REQ_TO_SECONDS = 1'b1
   } req_kind_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DIV   = 6'b000010,
      ST_YEAR  = 6'b000100,
      ST_MONTH = 6'b001000,
      ST_MAC   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   // gregorian rule for offsets from 2000; only 100 is a skipped century below 128
   function automatic logic leap_offset(input logic [6:0] y);
      return (y[1:0] == 2'b00) && (y != 7'd100);
   endfunction

   // leap years among offsets 0 .. y-1
   function automatic logic [4:0] leaps_before(input logic [6:0] y);
      logic [7:0] q4;
      logic [7:0] c100;
      logic [7:0] c400;
      q4   = (8'(y) + 8'd3) >> 2;
      c100 = (y == 7'd0) ? 8'd0 : ((y <= 7'd100) ? 8'd1 : 8'd2);
      c400 = (y == 7'd0) ? 8'd0 : 8'd1;
      return 5'(q4 - c100 + c400);
   endfunction

endpackage

>>> design/unix_time_calendar_converter.sv
// ----------------------------------------------------------------------------
// Unix time calendar converter
// Converts 32-bit Unix seconds to a date counted from 2000, and back.
// ----------------------------------------------------------------------------
// One item at a time, one result per item. Seconds to date divides by 60, 60
// and 24 as reciprocal multiplications on one shared multiplier, each division a
// quotient step and then a remainder step, then walks the year offsets and then
// the months up to the result month on a shared subtractor. Date to seconds runs
// four multiply-add steps on the same multiplier. Seconds before 2000 go straight
// to the final step with out_of_range set. The result register holds a finished
// item while the next one is accepted and worked on; a result still stalled
// there holds the block in its final step.
`include "unix_time_calendar_converter_assert.svh"

module unix_time_calendar_converter
   import utcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [31:0] req_epoch_seconds,
   input  logic [6:0]  req_year_offset,
   input  logic [3:0]  req_month_in,
   input  logic [4:0]  req_day_in,
   input  logic [4:0]  req_hour_in,
   input  logic [5:0]  req_minute_in,
   input  logic [5:0]  req_second_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_seconds,
   output logic [6:0]  rsp_result_year_offset,
   output logic [3:0]  rsp_result_month,
   output logic [4:0]  rsp_result_day,
   output logic [4:0]  rsp_result_hour,
   output logic [5:0]  rsp_result_minute,
   output logic [5:0]  rsp_result_second,
   output logic        rsp_out_of_range
);

   state_type    state_ff, state_in;
   logic         rsp_valid_ff, rsp_valid_in;

   req_kind_type kind_ff, kind_in;
   logic         oor_ff, oor_in;
   logic [31:0]  num_ff, num_in;
   logic [5:0]   rem_ff, rem_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic [1:0]   div_sel_ff, div_sel_in;
   logic [5:0]   sec_ff, sec_in;
   logic [5:0]   min_ff, min_in;
   logic [4:0]   hour_ff, hour_in;
   logic [16:0]  days_ff, days_in;
   logic [6:0]   year_ff, year_in;
   logic [3:0]   month_ff, month_in;
   logic         leap_ff, leap_in;

   logic [31:0] out_seconds_ff, out_seconds_in;
   logic [6:0]  out_year_ff, out_year_in;
   logic [3:0]  out_month_ff, out_month_in;
   logic [4:0]  out_day_ff, out_day_in;
   logic [4:0]  out_hour_ff, out_hour_in;
   logic [5:0]  out_minute_ff, out_minute_in;
   logic [5:0]  out_second_ff, out_second_in;
   logic        out_oor_ff, out_oor_in;

   // shared subtract and compare unit
   logic [16:0] sub_a, sub_b;
   logic [17:0] sub_diff;
   logic        sub_ge;

   // shared multiplier
   logic [31:0] mul_b;
   logic [63:0] mul_prod;

   logic        accept;
   logic        load_out;
   logic [31:0] div_quot;
   logic [5:0]  div_rem;
   logic        year_leap;
   logic [8:0]  year_len;
   logic [4:0]  month_len;
   logic [31:0] date_days;
   logic [5:0]  mac_k;
   logic [31:0] mac_add;
   logic [31:0] mac_sum;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   assign year_leap = leap_offset(year_ff);
   assign year_len  = year_leap ? 9'd366 : 9'd365;
   assign month_len = MONTH_LEN[4'(month_ff - 4'd1)] +
                      5'((leap_ff && (month_ff == 4'd2)) ? 1 : 0);

   always_comb begin
      sub_a = days_ff;
      sub_b = 17'(year_len);
      case (state_ff)
         ST_MONTH: begin
            sub_b = 17'(month_len);
         end
         default: begin
         end
      endcase
   end

   assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ge   = !sub_diff[17];

   assign mac_k = MAC_MUL[cnt_ff];

   always_comb begin
      mul_b = 32'(mac_k);
      if (state_ff == ST_DIV) begin
         if (!cnt_ff[0]) begin
            mul_b = (div_sel_ff == 2'd2) ? RECIP_24 : RECIP_60;
         end else begin
            mul_b = 32'(DIVISOR[div_sel_ff]);
         end
      end
   end

   assign mul_prod = 64'(num_ff) * 64'(mul_b);
   assign div_quot = (div_sel_ff == 2'd2) ? 32'(mul_prod[63:36]) : 32'(mul_prod[63:37]);
   assign div_rem  = rem_ff - mul_prod[5:0];

   assign date_days = 32'(req_day_in) + 32'(DAYS_BEFORE[req_month_in]) +
                      32'(((req_month_in > 4'd2) && leap_offset(req_year_offset)) ? 1 : 0) +
                      32'(16'(req_year_offset) * 16'd365) +
                      32'(leaps_before(req_year_offset)) - 32'd1;

   always_comb begin
      case (cnt_ff)
         2'd0:    mac_add = 32'(hour_ff);
         2'd1:    mac_add = 32'(min_ff);
         2'd2:    mac_add = 32'(sec_ff);
         default: mac_add = EPOCH_2000;
      endcase
   end
   assign mac_sum = mul_prod[31:0] + mac_add;

   assign load_out = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      oor_in     = oor_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      div_sel_in = div_sel_ff;
      sec_in     = sec_ff;
      min_in     = min_ff;
      hour_in    = hour_ff;
      days_in    = days_ff;
      year_in    = year_ff;
      month_in   = month_ff;
      leap_in    = leap_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in    = req_kind_type'(req_type);
               oor_in     = 1'b0;
               rem_in     = '0;
               cnt_in     = '0;
               div_sel_in = '0;
               if (req_type == REQ_TO_SECONDS) begin
                  num_in   = date_days;
                  hour_in  = req_hour_in;
                  min_in   = req_minute_in;
                  sec_in   = req_second_in;
                  state_in = ST_MAC;
               end else if (req_epoch_seconds < EPOCH_2000) begin
                  oor_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  num_in   = req_epoch_seconds - EPOCH_2000;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 2'd1;
            if (!cnt_ff[0]) begin
               rem_in = num_ff[5:0];
               num_in = div_quot;
            end else begin
               case (div_sel_ff)
                  2'd0:    sec_in  = div_rem;
                  2'd1:    min_in  = div_rem;
                  default: hour_in = 5'(div_rem);
               endcase
               div_sel_in = div_sel_ff + 2'd1;
               if (div_sel_ff == 2'd2) begin
                  days_in  = num_ff[16:0];
                  year_in  = '0;
                  state_in = ST_YEAR;
               end
            end
         end
         ST_YEAR: begin
            if (sub_ge) begin
               days_in = sub_diff[16:0];
               year_in = year_ff + 7'd1;
            end else begin
               leap_in  = year_leap;
               month_in = 4'd1;
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if ((month_ff == 4'd12) || !sub_ge) begin
               state_in = ST_DONE;
            end else begin
               days_in  = sub_diff[16:0];
               month_in = month_ff + 4'd1;
            end
         end
         ST_MAC: begin
            num_in = mac_sum;
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_seconds_in = out_seconds_ff;
      out_year_in    = out_year_ff;
      out_month_in   = out_month_ff;
      out_day_in     = out_day_ff;
      out_hour_in    = out_hour_ff;
      out_minute_in  = out_minute_ff;
      out_second_in  = out_second_ff;
      out_oor_in     = out_oor_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (load_out) begin
         rsp_valid_in   = 1'b1;
         out_seconds_in = '0;
         out_year_in    = '0;
         out_month_in   = '0;
         out_day_in     = '0;
         out_hour_in    = '0;
         out_minute_in  = '0;
         out_second_in  = '0;
         out_oor_in     = 1'b0;
         if (kind_ff == REQ_TO_SECONDS) begin
            out_seconds_in = num_ff;
         end else if (oor_ff) begin
            out_oor_in = 1'b1;
         end else begin
            out_year_in   = year_ff;
            out_month_in  = month_ff;
            out_day_in    = 5'(days_ff + 17'd1);
            out_hour_in   = hour_ff;
            out_minute_in = min_ff;
            out_second_in = sec_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      oor_ff         <= oor_in;
      num_ff         <= num_in;
      rem_ff         <= rem_in;
      cnt_ff         <= cnt_in;
      div_sel_ff     <= div_sel_in;
      sec_ff         <= sec_in;
      min_ff         <= min_in;
      hour_ff        <= hour_in;
      days_ff        <= days_in;
      year_ff        <= year_in;
      month_ff       <= month_in;
      leap_ff        <= leap_in;
      out_seconds_ff <= out_seconds_in;
      out_year_ff    <= out_year_in;
      out_month_ff   <= out_month_in;
      out_day_ff     <= out_day_in;
      out_hour_ff    <= out_hour_in;
      out_minute_ff  <= out_minute_in;
      out_second_ff  <= out_second_in;
      out_oor_ff     <= out_oor_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_result_seconds     = out_seconds_ff;
   assign rsp_result_year_offset = out_year_ff;
   assign rsp_result_month       = out_month_ff;
   assign rsp_result_day         = out_day_ff;
   assign rsp_result_hour        = out_hour_ff;
   assign rsp_result_minute      = out_minute_ff;
   assign rsp_result_second      = out_second_ff;
   assign rsp_out_of_range       = out_oor_ff;

   `UTC_ASSERT_NEXT(a_accept_busy, accept, state_ff != ST_IDLE)
   `UTC_ASSERT(a_rsp_from_done, $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
   `UTC_ASSERT(a_oor_zero, (rsp_valid && out_oor_ff) |-> (out_month_ff == '0 && out_year_ff == '0))
   `UTC_ASSERT(a_month_range, (state_ff == ST_MONTH) |-> (month_ff >= 4'd1 && month_ff <= 4'd12))

endmodule

>>> tb/unix_time_calendar_checker.sv
// ----------------------------------------------------------------------------
// Unix time calendar converter checker
// Watches both channels, predicts the date or seconds result of each accepted
// item, and compares every field of each returned item against the oldest
// prediction. Failures are counted and handed to the top.
// ----------------------------------------------------------------------------
package utcc_tb_pkg;

   typedef enum logic {
      OP_TO_DATE    = 1'b0,
      OP_TO_SECONDS = 1'b1
   } convert_op_type;

endpackage

module unix_time_calendar_checker
   import utcc_tb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_type,
   input  logic [31:0] req_epoch_seconds,
   input  logic [6:0]  req_year_offset,
   input  logic [3:0]  req_month_in,
   input  logic [4:0]  req_day_in,
   input  logic [4:0]  req_hour_in,
   input  logic [5:0]  req_minute_in,
   input  logic [5:0]  req_second_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_result_seconds,
   input  logic [6:0]  rsp_result_year_offset,
   input  logic [3:0]  rsp_result_month,
   input  logic [4:0]  rsp_result_day,
   input  logic [4:0]  rsp_result_hour,
   input  logic [5:0]  rsp_result_minute,
   input  logic [5:0]  rsp_result_second,
   input  logic        rsp_out_of_range,
   output int          mismatches,
   output int          pending_items
);

   typedef struct packed {
      logic [31:0] seconds;
      logic [6:0]  year_offset;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        out_of_range;
   } calendar_result_type;

   localparam logic [31:0] SECONDS_AT_2000 = 32'd946684800;

   localparam int unsigned CUM_DAYS [16] = '{
      0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365, 365, 365
   };

   localparam int unsigned MONTH_DAYS [12] = '{
      31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
   };

   calendar_result_type expected_q [$];

   function automatic bit is_leap_offset(input int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int unsigned leap_days_before(input int unsigned y);
      return (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
   endfunction

   function automatic int unsigned days_in_year(input int unsigned y);
      return is_leap_offset(y) ? 366 : 365;
   endfunction

   function automatic calendar_result_type date_from_seconds(input logic [31:0] secs);
      calendar_result_type r;
      logic [31:0] t;
      logic [31:0] days;
      int unsigned y;
      int unsigned m;
      int unsigned len;
      bit leap;
      r = '0;
      if (secs < SECONDS_AT_2000) begin
         r.out_of_range = 1'b1;
         return r;
      end
      t = secs - SECONDS_AT_2000;
      r.second = 6'(t % 60);
      t = t / 60;
      r.minute = 6'(t % 60);
      t = t / 60;
      r.hour = 5'(t % 24);
      days = t / 24;
      y = 0;
      while (y < 127 && days >= days_in_year(y)) begin
         days = days - days_in_year(y);
         y++;
      end
      leap = is_leap_offset(y);
      m = 1;
      len = MONTH_DAYS[0];
      while (m < 12 && days >= len) begin
         days = days - len;
         m++;
         len = MONTH_DAYS[m - 1] + ((leap && m == 2) ? 1 : 0);
      end
      r.year_offset = 7'(y);
      r.month = 4'(m);
      r.day = 5'(days + 1);
      return r;
   endfunction

   function automatic calendar_result_type seconds_from_date(
      input logic [6:0] yo,
      input logic [3:0] mo,
      input logic [4:0] dy,
      input logic [4:0] hr,
      input logic [5:0] mi,
      input logic [5:0] se
   );
      calendar_result_type r;
      logic [31:0] days;
      logic [31:0] t;
      r = '0;
      days = 32'(dy) + CUM_DAYS[mo];
      if (mo > 2 && is_leap_offset(yo))
         days = days + 32'd1;
      days = days + 32'd365 * 32'(yo) + leap_days_before(yo) - 32'd1;
      t = ((days * 32'd24 + 32'(hr)) * 32'd60 + 32'(mi)) * 32'd60 + 32'(se);
      r.seconds = t + SECONDS_AT_2000;
      return r;
   endfunction

   task automatic report_failure(
      input string               what,
      input calendar_result_type want,
      input calendar_result_type got
   );
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s at %0t", what, $time);
         $display("  expected secs=%0d date=%0d/%0d/%0d %0d:%0d:%0d oor=%0b",
            want.seconds, want.year_offset, want.month, want.day,
            want.hour, want.minute, want.second, want.out_of_range);
         $display("  actual   secs=%0d date=%0d/%0d/%0d %0d:%0d:%0d oor=%0b",
            got.seconds, got.year_offset, got.month, got.day,
            got.hour, got.minute, got.second, got.out_of_range);
      end
   endtask

   always @(posedge clock) begin : monitor
      calendar_result_type got;
      calendar_result_type want;
      if (reset) begin
         expected_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_result_seconds, rsp_result_year_offset, rsp_result_month,
                   rsp_result_day, rsp_result_hour, rsp_result_minute,
                   rsp_result_second, rsp_out_of_range};
            if (expected_q.size() == 0) begin
               report_failure("result item with nothing expected", '0, got);
            end else begin
               want = expected_q.pop_front();
               if (got !== want)
                  report_failure("result item mismatch", want, got);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_type == OP_TO_SECONDS)
               expected_q.push_back(seconds_from_date(req_year_offset, req_month_in,
                  req_day_in, req_hour_in, req_minute_in, req_second_in));
            else
               expected_q.push_back(date_from_seconds(req_epoch_seconds));
         end
      end
      pending_items = expected_q.size();
   end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Unix time calendar converter testbench
// Drives directed and random conversion requests in both directions with
// random gaps and stalls, one long result hold-off, and reports the verdict
// from the checker's failure and pending item counts.
// ----------------------------------------------------------------------------
module tb;
   import utcc_tb_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = OP_TO_DATE;
   logic [31:0] req_epoch_seconds = '0;
   logic [6:0]  req_year_offset = '0;
   logic [3:0]  req_month_in = '0;
   logic [4:0]  req_day_in = '0;
   logic [4:0]  req_hour_in = '0;
   logic [5:0]  req_minute_in = '0;
   logic [5:0]  req_second_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_result_seconds;
   logic [6:0]  rsp_result_year_offset;
   logic [3:0]  rsp_result_month;
   logic [4:0]  rsp_result_day;
   logic [4:0]  rsp_result_hour;
   logic [5:0]  rsp_result_minute;
   logic [5:0]  rsp_result_second;
   logic        rsp_out_of_range;
   int          mismatches;
   int          pending_items;

   bit gaps_enabled = 1'b1;
   bit drain_hold = 1'b0;
   bit hold_done = 1'b0;

   localparam logic [63:0] EPOCH_2000_SECS = 64'd946684800;
   localparam logic [63:0] AVG_YEAR_SECS   = 64'd31556952;
   localparam logic [63:0] AVG_MONTH_SECS  = 64'd2629746;

   unix_time_calendar_converter dut (.*);

   unix_time_calendar_checker checker_inst (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic offer_request(
      input convert_op_type op,
      input logic [31:0]    secs,
      input logic [6:0]     yo,
      input logic [3:0]     mo,
      input logic [4:0]     dy,
      input logic [4:0]     hr,
      input logic [5:0]     mi,
      input logic [5:0]     se
   );
      while (gaps_enabled && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_epoch_seconds <= secs;
      req_year_offset <= yo;
      req_month_in <= mo;
      req_day_in <= dy;
      req_hour_in <= hr;
      req_minute_in <= mi;
      req_second_in <= se;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic send_to_date(input logic [31:0] secs);
      offer_request(OP_TO_DATE, secs, 7'($urandom), 4'($urandom), 5'($urandom),
         5'($urandom), 6'($urandom), 6'($urandom));
   endtask

   task automatic send_to_seconds(
      input logic [6:0] yo,
      input logic [3:0] mo,
      input logic [4:0] dy,
      input logic [4:0] hr,
      input logic [5:0] mi,
      input logic [5:0] se
   );
      offer_request(OP_TO_SECONDS, $urandom, yo, mo, dy, hr, mi, se);
   endtask

   task automatic send_plain_date();
      send_to_seconds(7'($urandom_range(106)), 4'($urandom_range(12, 1)),
         5'($urandom_range(31, 1)), 5'($urandom_range(23)),
         6'($urandom_range(59)), 6'($urandom_range(59)));
   endtask

   task automatic random_batch(input int count);
      int unsigned pick;
      logic [63:0] stamp;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            send_to_date($urandom);
         end else if (pick < 24) begin
            send_to_date($urandom_range(32'hFFFF_FFFF, 32'd946684800));
         end else if (pick < 45) begin
            // land near a year or month boundary
            stamp = EPOCH_2000_SECS + 64'($urandom_range(106)) * AVG_YEAR_SECS
                  + 64'($urandom_range(345600)) - 64'd172800;
            if ($urandom_range(1))
               stamp = stamp + 64'($urandom_range(11)) * AVG_MONTH_SECS;
            send_to_date(32'(stamp));
         end else if (pick < 88) begin
            send_plain_date();
         end else begin
            send_to_seconds(7'($urandom), 4'($urandom), 5'($urandom),
               5'($urandom), 6'($urandom), 6'($urandom));
         end
      end
   endtask

   initial begin : receiver
      forever begin
         @(posedge clock);
         if (drain_hold && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (500) @(posedge clock);
            hold_done = 1'b1;
         end
         rsp_stall <= gaps_enabled && ($urandom_range(99) < 10);
      end
   end

   initial begin : watchdog
      #15_000_000;
      $display("FAIL unix_time_calendar_converter");
      $finish;
   end

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // seconds to date: range edges, leap days, the skipped century
      send_to_date(32'd0);
      send_to_date(32'd946684799);
      send_to_date(32'd946684800);
      send_to_date(32'd951782399);
      send_to_date(32'd951782400);
      send_to_date(32'd951868800);
      send_to_date(32'd978307199);
      send_to_date(32'd4102444799);
      send_to_date(32'd4107542399);
      send_to_date(32'd4107542400);
      send_to_date(32'hFFFF_FFFF);

      // date to seconds: edges, month 0, months past 12, day 0, wrap
      send_to_seconds(7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
      send_to_seconds(7'd0, 4'd2, 5'd29, 5'd12, 6'd30, 6'd30);
      send_to_seconds(7'd0, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
      send_to_seconds(7'd100, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59);
      send_to_seconds(7'd100, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
      send_to_seconds(7'd106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15);
      send_to_seconds(7'd106, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
      send_to_seconds(7'd5, 4'd0, 5'd15, 5'd1, 6'd2, 6'd3);
      send_to_seconds(7'd4, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0);
      send_to_seconds(7'd4, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
      send_to_seconds(7'd0, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0);
      send_to_seconds(7'd1, 4'd2, 5'd31, 5'd10, 6'd10, 6'd10);
      send_to_seconds(7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
      send_to_seconds(7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);

      random_batch(200);

      // receiver holds off while short items pile up behind it
      drain_hold = 1'b1;
      repeat (20) send_plain_date();

      gaps_enabled = 1'b0;
      random_batch(200);
      gaps_enabled = 1'b1;
      random_batch(200);
      req_valid <= 1'b0;
      @(posedge clock);

      while (pending_items != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);

      if (mismatches == 0 && pending_items == 0)
         $display("PASS unix_time_calendar_converter");
      else
         $display("FAIL unix_time_calendar_converter");
      $finish;
   end

endmodule
